### hw/rtl/vtgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtgd_pkg
// Types, command codes and helpers for the vector tile geometry decoder.
// ----------------------------------------------------------------------------
package vtgd_pkg;

    localparam int WORD_W   = 32;
    localparam int OP_W     = 3;
    localparam int COUNT_W  = WORD_W - OP_W;
    localparam int OUT_W    = 32;

    // Command identifiers
    localparam logic [OP_W-1:0] CMD_MOVE_TO    = 3'd1;
    localparam logic [OP_W-1:0] CMD_LINE_TO    = 3'd2;
    localparam logic [OP_W-1:0] CMD_CLOSE_PATH = 3'd7;

    // Event kinds
    localparam logic [1:0] EV_VERTEX = 2'd0;
    localparam logic [1:0] EV_CLOSE  = 2'd1;
    localparam logic [1:0] EV_ERROR  = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] geom_word;
        logic              feature_start;
    } vtgd_in_t;

    typedef struct packed {
        logic [1:0]              event_kind;
        logic signed [OUT_W-1:0] vertex_x;
        logic signed [OUT_W-1:0] vertex_y;
        logic                    ring_break;
        logic [COUNT_W-1:0]      close_repeat;
    } vtgd_out_t;

    function automatic logic [WORD_W-1:0] unzigzag(input logic [WORD_W-1:0] z);
        return (z >> 1) ^ {WORD_W{z[0]}};
    endfunction

endpackage

### hw/rtl/vector_tile_geometry_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_tile_geometry_decoder
// Decodes a geometry command stream into absolute vertices, ring close
// events and unknown command errors, one word per transaction.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+---------------------------
//  in      | input     | in_valid / in_ready  | vtgd_in_t  (word, start)
//  out     | output    | out_valid / out_ready| vtgd_out_t (event fields)
//
//  One word per cycle while in_ready is high: decode, zigzag and cursor add sit
//  between the state registers and the result register (or the skid slot when
//  it is stalled). A word that yields no event just updates the state.
//  rst_n clears the parser, cursor and both result slots.
//  A skid slot behind the result register keeps in_ready high for one stalled
//  result; in_ready drops only while the skid slot is full.
// ----------------------------------------------------------------------------
module vector_tile_geometry_decoder #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vtgd_pkg::vtgd_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output vtgd_pkg::vtgd_out_t out_data
);
    import vtgd_pkg::*;

    logic [OP_W-1:0]        cmd_reg, cmd_next;
    logic [COUNT_W-1:0]     remaining_reg, remaining_next;
    logic                   expect_second_reg, expect_second_next;
    logic [WORD_W-1:0]      held_dx_reg, held_dx_next;
    logic [COORD_WIDTH-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_WIDTH-1:0] cursor_y_reg, cursor_y_next;
    logic                   ring_has_reg, ring_has_next;
    logic                   error_stuck_reg, error_stuck_next;

    logic      out_valid_reg, out_valid_next;
    vtgd_out_t out_reg, out_next;
    logic      skid_valid_reg, skid_valid_next;
    vtgd_out_t skid_reg, skid_next;

    // state seen by this word, after a feature start has cleared it
    logic [OP_W-1:0]        cmd_cur;
    logic [COUNT_W-1:0]     remaining_cur;
    logic                   expect_second_cur;
    logic [WORD_W-1:0]      held_dx_cur;
    logic [COORD_WIDTH-1:0] cursor_x_cur, cursor_y_cur;
    logic                   ring_has_cur, error_stuck_cur;

    logic [OP_W-1:0]               w_cmd;
    logic [COUNT_W-1:0]            w_cnt;
    logic [WORD_W-1:0]             dx_full, dy_full;
    logic signed [COORD_WIDTH-1:0] sx, sy;
    logic                          accept, pop, has_result;
    vtgd_out_t                     result;

    assign accept = in_valid && in_ready;
    assign pop    = out_valid_reg && out_ready;
    assign w_cmd  = in_data.geom_word[OP_W-1:0];
    assign w_cnt  = in_data.geom_word[WORD_W-1:OP_W];

    always_comb
    begin
        if (in_data.feature_start)
        begin
            cmd_cur           = '0;
            remaining_cur     = '0;
            expect_second_cur = 1'b0;
            held_dx_cur       = '0;
            cursor_x_cur      = '0;
            cursor_y_cur      = '0;
            ring_has_cur      = 1'b0;
            error_stuck_cur   = 1'b0;
        end
        else
        begin
            cmd_cur           = cmd_reg;
            remaining_cur     = remaining_reg;
            expect_second_cur = expect_second_reg;
            held_dx_cur       = held_dx_reg;
            cursor_x_cur      = cursor_x_reg;
            cursor_y_cur      = cursor_y_reg;
            ring_has_cur      = ring_has_reg;
            error_stuck_cur   = error_stuck_reg;
        end
    end

    assign dx_full = unzigzag(held_dx_cur);
    assign dy_full = unzigzag(in_data.geom_word);

    always_comb
    begin
        cmd_next           = cmd_cur;
        remaining_next     = remaining_cur;
        expect_second_next = expect_second_cur;
        held_dx_next       = held_dx_cur;
        cursor_x_next      = cursor_x_cur;
        cursor_y_next      = cursor_y_cur;
        ring_has_next      = ring_has_cur;
        error_stuck_next   = error_stuck_cur;
        has_result         = 1'b0;
        result             = '0;
        sx                 = '0;
        sy                 = '0;

        if (error_stuck_cur)
        begin
            // drop the word
        end
        else if (remaining_cur == '0)
        begin
            if (w_cnt != '0)
            begin
                cmd_next = w_cmd;
                if (w_cmd == CMD_MOVE_TO || w_cmd == CMD_LINE_TO)
                begin
                    remaining_next     = w_cnt;
                    expect_second_next = 1'b0;
                end
                else if (w_cmd == CMD_CLOSE_PATH)
                begin
                    ring_has_next       = 1'b0;
                    has_result          = 1'b1;
                    result.event_kind   = EV_CLOSE;
                    result.close_repeat = w_cnt;
                end
                else
                begin
                    error_stuck_next  = 1'b1;
                    has_result        = 1'b1;
                    result.event_kind = EV_ERROR;
                end
            end
        end
        else if (!expect_second_cur)
        begin
            held_dx_next       = in_data.geom_word;
            expect_second_next = 1'b1;
        end
        else
        begin
            cursor_x_next      = cursor_x_cur + dx_full[COORD_WIDTH-1:0];
            cursor_y_next      = cursor_y_cur + dy_full[COORD_WIDTH-1:0];
            expect_second_next = 1'b0;
            remaining_next     = remaining_cur - COUNT_W'(1);
            sx                 = cursor_x_next;
            sy                 = cursor_y_next;
            has_result         = 1'b1;
            result.event_kind  = EV_VERTEX;
            // sign extend from the top coordinate bit
            result.vertex_x    = OUT_W'(sx);
            result.vertex_y    = OUT_W'(sy);
            result.ring_break  = (cmd_cur == CMD_MOVE_TO) && ring_has_cur;
            ring_has_next      = 1'b1;
        end
    end

    // result register with one skid slot; accept implies the skid is empty
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (accept && has_result)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg           <= '0;
            remaining_reg     <= '0;
            expect_second_reg <= 1'b0;
            held_dx_reg       <= '0;
            cursor_x_reg      <= '0;
            cursor_y_reg      <= '0;
            ring_has_reg      <= 1'b0;
            error_stuck_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cmd_reg           <= cmd_next;
                remaining_reg     <= remaining_next;
                expect_second_reg <= expect_second_next;
                held_dx_reg       <= held_dx_next;
                cursor_x_reg      <= cursor_x_next;
                cursor_y_reg      <= cursor_y_next;
                ring_has_reg      <= ring_has_next;
                error_stuck_reg   <= error_stuck_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full while result register empty");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid slot filled without a stalled result");

    a_pair_in_command: assert property (@(posedge clk) disable iff (!rst_n)
        expect_second_reg |-> (remaining_reg != '0))
        else $error("held x delta outside a MoveTo or LineTo run");

    a_stuck_idle: assert property (@(posedge clk) disable iff (!rst_n)
        error_stuck_reg |-> (remaining_reg == '0))
        else $error("error state with a pending repeat count");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for vector_tile_geometry_decoder. Feeds geometry word
// streams (corner cases, then mostly well-formed random features mixed with
// noise and broken ones) with and without random idling on both channels,
// predicts every event in a behavioural decoder and checks them in order.
// ----------------------------------------------------------------------------
module testbench;
    import vtgd_pkg::*;

    localparam int COORD_W      = 32;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int PHASE_WORDS  = 600;
    localparam longint TIMEOUT_NS = 2_000_000;
    localparam logic [63:0] COORD_MASK64 = (64'd1 << COORD_W) - 64'd1;
    localparam logic [31:0] COORD_MASK = COORD_MASK64[31:0];

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    vtgd_in_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    vtgd_out_t out_data;

    vtgd_out_t pending_events[$];
    int        error_count = 0;
    int        words_counted = 0;
    int        src_idle_pct = 0;
    int        sink_idle_pct = 0;
    int        hold_asked = 0;
    int        hold_seen = 0;
    int        hold_left = 0;

    // decoder state as predicted
    logic [2:0]  dec_cmd = '0;
    logic [28:0] dec_left = '0;
    logic        dec_want_dy = 1'b0;
    logic [31:0] dec_dx = '0;
    logic [31:0] dec_cur_x = '0;
    logic [31:0] dec_cur_y = '0;
    logic        dec_ring_open = 1'b0;
    logic        dec_jammed = 1'b0;

    vector_tile_geometry_decoder #(
        .COORD_WIDTH(COORD_W)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [31:0] zz_decode(input logic [31:0] z);
        return (z >> 1) ^ (32'd0 - {31'd0, z[0]});
    endfunction

    function automatic logic [31:0] zz_encode(input int v);
        return (v <<< 1) ^ (v >>> 31);
    endfunction

    function automatic logic [31:0] to_coord_out(input logic [31:0] v);
        logic [31:0] m;
        m = v & COORD_MASK;
        if (m[COORD_W-1])
            m = m | ~COORD_MASK;
        return m;
    endfunction

    function automatic logic [31:0] cmd_word(input logic [2:0] id, input logic [28:0] cnt);
        return {cnt, id};
    endfunction

    // Advance the predicted decoder by one word; returns 1 when an event is due.
    function automatic bit decode_word(input vtgd_in_t item, output vtgd_out_t ev);
        logic [2:0]  id;
        logic [28:0] cnt;
        ev = '0;
        if (item.feature_start)
        begin
            dec_cmd       = '0;
            dec_left      = '0;
            dec_want_dy   = 1'b0;
            dec_dx        = '0;
            dec_cur_x     = '0;
            dec_cur_y     = '0;
            dec_ring_open = 1'b0;
            dec_jammed    = 1'b0;
        end
        if (dec_jammed)
            return 0;
        if (dec_left == 0)
        begin
            id  = item.geom_word[2:0];
            cnt = item.geom_word[31:3];
            if (cnt == 0)
                return 0;
            dec_cmd  = id;
            if (id == CMD_MOVE_TO || id == CMD_LINE_TO)
            begin
                dec_left    = cnt;
                dec_want_dy = 1'b0;
                return 0;
            end
            if (id == CMD_CLOSE_PATH)
            begin
                dec_ring_open   = 1'b0;
                ev.event_kind   = EV_CLOSE;
                ev.close_repeat = cnt;
                return 1;
            end
            dec_jammed    = 1'b1;
            ev.event_kind = EV_ERROR;
            return 1;
        end
        if (!dec_want_dy)
        begin
            dec_dx      = item.geom_word;
            dec_want_dy = 1'b1;
            return 0;
        end
        dec_cur_x     = (dec_cur_x + zz_decode(dec_dx)) & COORD_MASK;
        dec_cur_y     = (dec_cur_y + zz_decode(item.geom_word)) & COORD_MASK;
        dec_want_dy   = 1'b0;
        dec_left      = dec_left - 29'd1;
        ev.event_kind = EV_VERTEX;
        ev.vertex_x   = to_coord_out(dec_cur_x);
        ev.vertex_y   = to_coord_out(dec_cur_y);
        ev.ring_break = (dec_cmd == CMD_MOVE_TO) && dec_ring_open;
        dec_ring_open = 1'b1;
        return 1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        // keep the log short when the block is badly broken
        if (error_count < 200)
            $display("MISMATCH %s: got %0h, wanted %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Offer one word, hold it until taken, then record the event it causes.
    task automatic offer_word(input logic [31:0] w, input logic fs);
        vtgd_in_t  item;
        vtgd_out_t ev;
        bit        due;
        item.geom_word     = w;
        item.feature_start = fs;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        due = decode_word(item, ev);
        if (due)
            pending_events.insert(pending_events.size(), ev);
        words_counted++;
    endtask

    // Stop sending and wait for every outstanding event.
    task automatic drain_events();
        int n;
        in_valid <= 1'b0;
        n = 0;
        while (pending_events.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        if (pending_events.size() != 0)
        begin
            report_mismatch("events never produced", 64'(pending_events.size()), 64'd0);
            pending_events.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [2:0] pick_unknown_id();
        logic [2:0] id;
        do
            id = 3'($urandom_range(0, 7));
        while (id == CMD_MOVE_TO || id == CMD_LINE_TO || id == CMD_CLOSE_PATH);
        return id;
    endfunction

    function automatic logic [31:0] rand_delta();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return zz_encode(int'($urandom_range(0, 200)) - 100);
        else if (r < 80)
            return $urandom;
        else if (r < 90)
            return 32'hFFFF_FFFF - $urandom_range(0, 3);
        else
            return $urandom_range(0, 3);
    endfunction

    task automatic test_corner_cases();
        logic [2:0] id;
        bit         first;
        offer_word(cmd_word(CMD_MOVE_TO, 29'd1), 1'b1);
        offer_word(32'hFFFF_FFFF, 1'b0);            // most negative x step
        offer_word(32'hFFFF_FFFE, 1'b0);            // most positive y step
        offer_word(cmd_word(CMD_LINE_TO, 29'd1), 1'b0);
        offer_word(zz_encode(-1), 1'b0);            // cursor wraps both ways
        offer_word(zz_encode(1), 1'b0);
        offer_word(cmd_word(CMD_MOVE_TO, 29'd1), 1'b0);
        offer_word(zz_encode(5), 1'b0);
        offer_word(zz_encode(-7), 1'b0);            // ring break
        offer_word(cmd_word(CMD_LINE_TO, 29'd0), 1'b0);  // zero count: ignored
        offer_word(32'h0000_0000, 1'b0);
        offer_word(cmd_word(CMD_CLOSE_PATH, '1), 1'b0);  // widest close count
        offer_word(cmd_word(CMD_MOVE_TO, 29'd1), 1'b0);
        offer_word(zz_encode(3), 1'b0);
        offer_word(zz_encode(3), 1'b0);
        offer_word(cmd_word(CMD_CLOSE_PATH, 29'd1), 1'b0);
        offer_word(cmd_word(CMD_MOVE_TO, 29'd2), 1'b0);
        offer_word(zz_encode(9), 1'b0);             // pair left open
        offer_word(cmd_word(CMD_LINE_TO, 29'd1), 1'b1);
        offer_word(zz_encode(2), 1'b0);
        offer_word(zz_encode(2), 1'b0);
        // every unknown id, each in its own feature
        first = 1'b1;
        for (int k = 0; k < 8; k++)
        begin
            id = 3'(k);
            if (id != CMD_MOVE_TO && id != CMD_LINE_TO && id != CMD_CLOSE_PATH)
            begin
                offer_word(cmd_word(id, first ? 29'd1 : '1), 1'b1);
                if (first)
                    offer_word(cmd_word(CMD_CLOSE_PATH, 29'd1), 1'b0);  // dropped
                first = 1'b0;
            end
        end
    endtask

    task automatic gen_feature();
        int          n_cmds;
        int          r;
        int          n;
        logic [28:0] cnt;
        logic [2:0]  id;
        logic        fs;
        fs = 1'b1;
        n_cmds = $urandom_range(1, 6);
        for (int c = 0; c < n_cmds; c++)
        begin
            r = $urandom_range(99);
            if (r < 60)
            begin
                id  = (r < 25) ? CMD_MOVE_TO : CMD_LINE_TO;
                cnt = 29'($urandom_range(1, (r < 25) ? 3 : 6));
                offer_word(cmd_word(id, cnt), fs);
                fs = 1'b0;
                for (int k = 0; k < 2 * int'(cnt); k++)
                    offer_word(rand_delta(), 1'b0);
            end
            else if (r < 75)
            begin
                cnt = ($urandom_range(3) == 0) ? 29'($urandom) : 29'($urandom_range(1, 2));
                offer_word(cmd_word(CMD_CLOSE_PATH, cnt), fs);
                fs = 1'b0;
            end
            else if (r < 82)
            begin
                offer_word(cmd_word(3'($urandom_range(0, 7)), 29'd0), fs);
                fs = 1'b0;
            end
            else if (r < 88)
            begin
                cnt = 29'($urandom);
                if (cnt == 0)
                    cnt = 29'd1;
                offer_word(cmd_word(pick_unknown_id(), cnt), fs);
                n = $urandom_range(0, 3);
                repeat (n) offer_word($urandom, 1'b0);
                return;
            end
            else if (r < 94)
            begin
                // feature cut short in the middle of its pairs
                id  = $urandom_range(1) ? CMD_MOVE_TO : CMD_LINE_TO;
                cnt = $urandom_range(1) ? (29'($urandom) | 29'd1) : 29'($urandom_range(2, 5));
                offer_word(cmd_word(id, cnt), fs);
                n = $urandom_range(0, 5);
                repeat (n) offer_word(rand_delta(), 1'b0);
                return;
            end
            else
            begin
                offer_word($urandom, ($urandom_range(3) == 0));
                fs = 1'b0;
            end
        end
    endtask

    task automatic test_random_stream(input int src_pct, input int sink_pct);
        int target;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        target = words_counted + PHASE_WORDS;
        while (words_counted < target)
            gen_feature();
    endtask

    // Hold the receiver off while a long LineTo streams in, so the block fills.
    task automatic test_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_asked++;
        offer_word(cmd_word(CMD_MOVE_TO, 29'd1), 1'b1);
        offer_word(rand_delta(), 1'b0);
        offer_word(rand_delta(), 1'b0);
        offer_word(cmd_word(CMD_LINE_TO, 29'd24), 1'b0);
        repeat (48) offer_word(rand_delta(), 1'b0);
    endtask

    always @(posedge clk)
    begin
        if (hold_seen != hold_asked)
        begin
            hold_seen <= hold_asked;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        vtgd_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_events.size() == 0)
            begin
                report_mismatch("unexpected event", 64'(out_data.event_kind), 64'd0);
            end
            else
            begin
                want = pending_events.pop_front();
                if (out_data.event_kind !== want.event_kind)
                    report_mismatch("event_kind", 64'(out_data.event_kind),
                                    64'(want.event_kind));
                if (out_data.vertex_x !== want.vertex_x)
                    report_mismatch("vertex_x", 64'(out_data.vertex_x), 64'(want.vertex_x));
                if (out_data.vertex_y !== want.vertex_y)
                    report_mismatch("vertex_y", 64'(out_data.vertex_y), 64'(want.vertex_y));
                if (out_data.ring_break !== want.ring_break)
                    report_mismatch("ring_break", 64'(out_data.ring_break),
                                    64'(want.ring_break));
                if (out_data.close_repeat !== want.close_repeat)
                    report_mismatch("close_repeat", 64'(out_data.close_repeat),
                                    64'(want.close_repeat));
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct  = 20;
        sink_idle_pct = 59;
        test_corner_cases();
        drain_events();

        test_random_stream(20, 59);
        drain_events();

        test_backpressure();
        drain_events();

        test_random_stream(59, 20);
        drain_events();

        test_random_stream(0, 0);
        drain_events();

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
hw/rtl/vtgd_pkg.sv
hw/rtl/vector_tile_geometry_decoder.sv
verif/testbench.sv
